### design/mtat_pkg.sv
// Shared types and codes for the alarm window table.
// No dependencies; used by the controller, the datapath and the top level.
package mtat_pkg;

   localparam logic [1:0] OP_EVAL  = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [2:0] KIND_ALERT   = 3'd0;
   localparam logic [2:0] KIND_NONE    = 3'd1;
   localparam logic [2:0] KIND_ADDED   = 3'd2;
   localparam logic [2:0] KIND_FULL    = 3'd3;
   localparam logic [2:0] KIND_CLEARED = 3'd4;

   typedef struct packed {
      logic               enable;
      logic [7:0]         severity;
      logic signed [31:0] high;
      logic signed [31:0] low;
      logic [31:0]        metric;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic do_add;
      logic do_clear;
      logic eval_none;
      logic start_scan;
      logic scan;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic scan_end;
   } sts_type;

endpackage

### design/mtat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### design/mtat_ctrl.sv
// Sequencer for the alarm window table: decodes requests and paces the scan.
// Depends on mtat_pkg for the command and status structs and opcodes.
module mtat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        req_opcode,
   input  mtat_pkg::sts_type sts,
   output mtat_pkg::cmd_type cmd,
   output logic              busy
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  mtat_pkg::OP_EVAL: begin
                     if (sts.empty) begin
                        cmd.eval_none = 1'b1;
                     end else begin
                        cmd.start_scan = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  mtat_pkg::OP_ADD:   cmd.do_add = 1'b1;
                  mtat_pkg::OP_CLEAR: cmd.do_clear = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_end) begin
               state_in = ST_DRAIN;
            end
         end
         // last read data is compared here
         ST_DRAIN: state_in = ST_FINISH;
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_scan_leads_to_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && sts.scan_end) |=> (state_ff == ST_DRAIN))
      else $error("scan end not followed by drain");

   a_no_cmd_when_busy_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !(cmd.do_add || cmd.do_clear || cmd.start_scan))
      else $error("request command issued while busy");

   a_scan_never_on_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.start_scan |-> !sts.empty)
      else $error("scan started on empty table");

endmodule

### design/mtat_dp.sv
// Datapath for the alarm window table: entry store, scan compare, alert
// numbering and the result register. Depends on mtat_pkg and mtat_ram.
module mtat_dp #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  mtat_pkg::cmd_type   cmd,
   output mtat_pkg::sts_type   sts,
   input  logic [31:0]         req_metric_key,
   input  logic [31:0]         req_sample_time,
   input  logic signed [31:0]  req_sample_value,
   input  logic signed [31:0]  req_lower_limit,
   input  logic signed [31:0]  req_upper_limit,
   input  logic [7:0]          req_entry_severity,
   input  logic                req_entry_enabled,
   output logic                rsp_valid,
   output logic [2:0]          rsp_result_kind,
   output logic [31:0]         rsp_alert_number,
   output logic [31:0]         rsp_alert_metric,
   output logic [31:0]         rsp_alert_time,
   output logic signed [31:0]  rsp_observed,
   output logic [7:0]          rsp_alert_severity,
   output logic                rsp_last_result
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int ENTRY_W = $bits(mtat_pkg::entry_type);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [31:0]        next_num_ff;
   logic               rd_vld_ff;
   logic               pend_ff;
   logic [31:0]        pend_num_ff;
   logic [7:0]         pend_sev_ff;
   logic [31:0]        key_ff;
   logic [31:0]        ts_ff;
   logic signed [31:0] val_ff;

   logic               rsp_valid_ff;
   logic [2:0]         kind_ff;
   logic [31:0]        num_ff;
   logic [31:0]        metric_ff;
   logic [31:0]        time_ff;
   logic signed [31:0] obs_ff;
   logic [7:0]         sev_ff;
   logic               last_ff;

   mtat_pkg::entry_type wentry;
   mtat_pkg::entry_type rentry;
   logic [ENTRY_W-1:0]  rdata;
   logic                we;
   logic                hit;

   assign sts.full     = (count_ff == CNT_W'(TABLE_DEPTH));
   assign sts.empty    = (count_ff == '0);
   assign sts.scan_end = ((idx_ff + CNT_W'(1)) == count_ff);

   assign we = cmd.do_add && !sts.full;
   always_comb begin
      wentry.enable   = req_entry_enabled;
      wentry.severity = req_entry_severity;
      wentry.high     = req_upper_limit;
      wentry.low      = req_lower_limit;
      wentry.metric   = req_metric_key;
   end

   mtat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock(clock),
      .we   (we),
      .waddr(count_ff[ADDR_W-1:0]),
      .wdata(wentry),
      .re   (cmd.scan),
      .raddr(idx_ff[ADDR_W-1:0]),
      .rdata(rdata)
   );

   assign rentry = mtat_pkg::entry_type'(rdata);
   assign hit = rd_vld_ff && rentry.enable && (rentry.metric == key_ff) &&
                ((val_ff < rentry.low) || (rentry.high < val_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         next_num_ff  <= 32'd1;
         rd_vld_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= cmd.scan;
         // a new hit pushes out the alert held back so far
         rsp_valid_ff <= (hit && pend_ff) || cmd.do_add || cmd.do_clear ||
                         cmd.eval_none || cmd.finish;
         if (we) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.do_clear) begin
            count_ff <= '0;
         end
         if (cmd.start_scan) begin
            pend_ff <= 1'b0;
         end
         if (hit) begin
            pend_ff     <= 1'b1;
            next_num_ff <= next_num_ff + 32'd1;
         end
         if (cmd.finish) begin
            pend_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_scan) begin
         idx_ff <= '0;
         key_ff <= req_metric_key;
         ts_ff  <= req_sample_time;
         val_ff <= req_sample_value;
      end else if (cmd.scan) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (hit) begin
         pend_num_ff <= next_num_ff;
         pend_sev_ff <= rentry.severity;
      end
      // result register; non-alert kinds carry zero fields
      if (hit && pend_ff) begin
         kind_ff   <= mtat_pkg::KIND_ALERT;
         num_ff    <= pend_num_ff;
         metric_ff <= key_ff;
         time_ff   <= ts_ff;
         obs_ff    <= val_ff;
         sev_ff    <= pend_sev_ff;
         last_ff   <= 1'b0;
      end else if (cmd.finish && pend_ff) begin
         kind_ff   <= mtat_pkg::KIND_ALERT;
         num_ff    <= pend_num_ff;
         metric_ff <= key_ff;
         time_ff   <= ts_ff;
         obs_ff    <= val_ff;
         sev_ff    <= pend_sev_ff;
         last_ff   <= 1'b1;
      end else if (cmd.do_add || cmd.do_clear || cmd.eval_none || cmd.finish) begin
         if (cmd.do_add) begin
            kind_ff <= sts.full ? mtat_pkg::KIND_FULL : mtat_pkg::KIND_ADDED;
         end else if (cmd.do_clear) begin
            kind_ff <= mtat_pkg::KIND_CLEARED;
         end else begin
            kind_ff <= mtat_pkg::KIND_NONE;
         end
         num_ff    <= '0;
         metric_ff <= '0;
         time_ff   <= '0;
         obs_ff    <= '0;
         sev_ff    <= '0;
         last_ff   <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_alert_number   = num_ff;
   assign rsp_alert_metric   = metric_ff;
   assign rsp_alert_time     = time_ff;
   assign rsp_observed       = obs_ff;
   assign rsp_alert_severity = sev_ff;
   assign rsp_last_result    = last_ff;

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_plain_result_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != mtat_pkg::KIND_ALERT) |->
      (last_ff && num_ff == '0 && sev_ff == '0))
      else $error("non-alert result with stray fields");

   a_inner_alert_leaves_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |-> pend_ff)
      else $error("non-final alert without a held alert behind it");

   a_hit_counts_up: assert property (@(posedge clock) disable iff (reset)
      hit |=> (next_num_ff == $past(next_num_ff) + 32'd1))
      else $error("alert number not advanced on hit");

endmodule

### design/metric_threshold_alarm_table.sv
// Top level of the alarm window table: controller plus datapath.
// Depends on mtat_pkg, mtat_ctrl, mtat_dp (and mtat_ram through mtat_dp).
//
//   channel   direction  handshake          payload
//   request   in         start & !busy      req_opcode .. req_entry_enabled
//   response  out        rsp_valid (1 cyc)  rsp_result_kind .. rsp_last_result
//
// Add, clear and unused opcodes keep busy low, so requests may follow back to
// back. Add and clear results appear the cycle after the beat; unused gives none.
// Evaluate on an empty table also keeps busy low and returns a none result.
// Otherwise busy is high for one RAM read per entry in insertion order, a drain
// state for the last registered read and a finish state for the final result.
// Synchronous reset empties the table and sets the alert number to 1; entry
// contents are not cleared. The receiver cannot stall: each beat shows once.
module metric_threshold_alarm_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [31:0]        req_metric_key,
   input  logic [31:0]        req_sample_time,
   input  logic signed [31:0] req_sample_value,
   input  logic signed [31:0] req_lower_limit,
   input  logic signed [31:0] req_upper_limit,
   input  logic [7:0]         req_entry_severity,
   input  logic               req_entry_enabled,
   output logic               rsp_valid,
   output logic [2:0]         rsp_result_kind,
   output logic [31:0]        rsp_alert_number,
   output logic [31:0]        rsp_alert_metric,
   output logic [31:0]        rsp_alert_time,
   output logic signed [31:0] rsp_observed,
   output logic [7:0]         rsp_alert_severity,
   output logic               rsp_last_result
);

   mtat_pkg::cmd_type cmd;
   mtat_pkg::sts_type sts;

   mtat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_opcode(req_opcode),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   mtat_dp #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_metric_key    (req_metric_key),
      .req_sample_time   (req_sample_time),
      .req_sample_value  (req_sample_value),
      .req_lower_limit   (req_lower_limit),
      .req_upper_limit   (req_upper_limit),
      .req_entry_severity(req_entry_severity),
      .req_entry_enabled (req_entry_enabled),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_alert_number  (rsp_alert_number),
      .rsp_alert_metric  (rsp_alert_metric),
      .rsp_alert_time    (rsp_alert_time),
      .rsp_observed      (rsp_observed),
      .rsp_alert_severity(rsp_alert_severity),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
